@@ design/ffra_pkg.sv @@
// ----------------------------------------------------------------------------
// ffra_pkg
// Types and constants shared by the first-fit region allocator modules.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int ID_W   = 15;
  localparam int SIZE_W = 24;
  localparam int OFF_W  = 25;
  localparam int ADDR_W = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BANK_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BANK_SIZE = 1'b1;

  localparam logic [ADDR_W-1:0] BANK_BASE_RESET = 32'h0000_0000;
  localparam logic [SIZE_W-1:0] BANK_SIZE_RESET = 24'h10_0000;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NO_GAP    = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHUP,
    S_INSERT,
    S_SHDN,
    S_DONE
  } state_t;

  // One table entry: id, start offset and end offset from the bank base.
  typedef struct packed {
    logic [ID_W-1:0]   rid;
    logic [SIZE_W-1:0] rstart;
    logic [OFF_W-1:0]  rend;
  } entry_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
  } request_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] addr;
    logic              present;
  } result_t;

endpackage

@@ design/ffra_ram.sv @@
// ----------------------------------------------------------------------------
// ffra_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ffra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/ffra_engine.sv @@
// ----------------------------------------------------------------------------
// ffra_engine
// Request sequencer: scans the sorted region table held in RAM, decides the
// outcome and shifts entries up or down to insert or remove one.
// ----------------------------------------------------------------------------
module ffra_engine
  import ffra_pkg::*;
#(
  parameter int ENTRY_COUNT = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  request_t          in_req,
  input  logic [ADDR_W-1:0] bank_base,
  input  logic [SIZE_W-1:0] bank_size,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  localparam int AW = $clog2(ENTRY_COUNT);
  localparam int CW = $clog2(ENTRY_COUNT + 1);

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     ri, ri_next;
  logic              rv, rv_next;
  logic [AW-1:0]     ea, ea_next;
  logic [CW-1:0]     pos, pos_next;
  logic [OFF_W-1:0]  prev, prev_next;
  logic              found, found_next;
  request_t          req, req_next;
  result_t           res_next;

  logic              re;
  logic [AW-1:0]     raddr;
  logic              we;
  logic [AW-1:0]     waddr;
  entry_t            wdata;
  entry_t            rdata;

  logic [OFF_W-1:0]  gap;
  logic              hit;
  logic              last;
  logic [OFF_W:0]    fit_end;

  ffra_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRY_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rv    <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rv    <= rv_next;
    end
  end

  always_ff @(posedge clk) begin
    ri    <= ri_next;
    ea    <= ea_next;
    pos   <= pos_next;
    prev  <= prev_next;
    found <= found_next;
    req   <= req_next;
    res   <= res_next;
  end

  // Gap in front of the entry just read, and the hit test for the scan.
  always_comb begin
    gap  = ({1'b0, rdata.rstart} >= prev) ? ({1'b0, rdata.rstart} - prev) : '0;
    hit  = (req.cmd == CMD_ALLOC) ? (gap >= {1'b0, req.size}) : (rdata.rid == req.id);
    last = ((CW'(ea) + CW'(1)) == count);
    fit_end = {1'b0, prev} + {2'b00, req.size};
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    state_next = state;
    count_next = count;
    ri_next    = ri;
    rv_next    = 1'b0;
    ea_next    = ea;
    pos_next   = pos;
    prev_next  = prev;
    found_next = found;
    req_next   = req;
    res_next   = res;
    re         = 1'b0;
    raddr      = ri[AW-1:0];
    we         = 1'b0;
    waddr      = ea;
    wdata      = rdata;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_next   = in_req;
          prev_next  = '0;
          ri_next    = '0;
          pos_next   = '0;
          found_next = 1'b0;
          res_next   = '0;
          case (in_req.cmd)
            CMD_ALLOC: begin
              if (count == CW'(ENTRY_COUNT)) begin
                res_next.status = ST_FULL;
                state_next      = S_DONE;
              end else if (count == '0) begin
                state_next = S_DECIDE;
              end else begin
                state_next = S_SCAN;
              end
            end
            CMD_FREE, CMD_QUERY: begin
              state_next = (count == '0) ? S_DECIDE : S_SCAN;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      // Reads are issued one per cycle; the entry read in the previous cycle
      // is checked while the next one is fetched.
      S_SCAN: begin
        if (rv && hit) begin
          pos_next   = CW'(ea);
          found_next = 1'b1;
          state_next = S_DECIDE;
        end else begin
          if (rv && (req.cmd == CMD_ALLOC)) begin
            prev_next = rdata.rend;
          end
          if (rv && last) begin
            pos_next   = count;
            state_next = S_DECIDE;
          end else if (ri < count) begin
            re      = 1'b1;
            raddr   = ri[AW-1:0];
            ri_next = ri + CW'(1);
            rv_next = 1'b1;
            ea_next = ri[AW-1:0];
          end
        end
      end

      S_DECIDE: begin
        case (req.cmd)
          CMD_ALLOC: begin
            if (fit_end > {2'b00, bank_size}) begin
              res_next.status = ST_NO_GAP;
              state_next      = S_DONE;
            end else begin
              res_next.status = ST_OK;
              res_next.addr   = bank_base + ADDR_W'(prev);
              ri_next         = count;
              state_next      = S_SHUP;
            end
          end
          CMD_FREE: begin
            if (!found) begin
              res_next.status = ST_NOT_FOUND;
              state_next      = S_DONE;
            end else begin
              ri_next    = pos + CW'(1);
              state_next = S_SHDN;
            end
          end
          CMD_QUERY: begin
            res_next.present = found;
            state_next       = S_DONE;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end

      // Open a hole at pos: move entries from the top down, one place up.
      // The write always lands on an entry already read or on the free slot at the top, so no forwarding.
      S_SHUP: begin
        if (rv) begin
          we    = 1'b1;
          waddr = AW'(CW'(ea) + CW'(1));
          wdata = rdata;
        end
        if (ri > pos) begin
          re      = 1'b1;
          raddr   = AW'(ri - CW'(1));
          ri_next = ri - CW'(1);
          rv_next = 1'b1;
          ea_next = AW'(ri - CW'(1));
        end else if (!rv) begin
          state_next = S_INSERT;
        end
      end

      S_INSERT: begin
        we           = 1'b1;
        waddr        = pos[AW-1:0];
        wdata.rid    = req.id;
        wdata.rstart = prev[SIZE_W-1:0];
        wdata.rend   = fit_end[OFF_W-1:0];
        count_next   = count + CW'(1);
        state_next   = S_DONE;
      end

      // Close the hole at pos: move entries above it one place down.
      S_SHDN: begin
        if (rv) begin
          we    = 1'b1;
          waddr = ea - AW'(1);
          wdata = rdata;
        end
        if (ri < count) begin
          re      = 1'b1;
          raddr   = ri[AW-1:0];
          ri_next = ri + CW'(1);
          rv_next = 1'b1;
          ea_next = ri[AW-1:0];
        end else if (!rv) begin
          count_next = count - CW'(1);
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/first_fit_region_allocator_top.sv @@
// ----------------------------------------------------------------------------
// first_fit_region_allocator_top
// First-fit allocator over a sorted table of live regions in one bank.
// ----------------------------------------------------------------------------
//  Port group  Dir   Carries
//  s_*         in    request: tuser = command, tdata = object_id, request_size
//  m_*         out   result:  tdata = status, region_address, present
//  cfg_*       in    register writes: bank_base (index 0), bank_size (index 1)
//
//  A request walks the table RAM one entry per cycle; a no-op or an allocate
//  into a full table is the shortest request, an allocate into an almost
//  full table the longest. The scan stops where the shift starts, so together
//  they cover the table once; an allocate reads the entry at that point twice.
//  One request is worked on at a time; a new one is taken while the previous
//  result still waits in the output register.
//  Reset empties the table at once; table contents are not cleared.
//  A stalled result holds the engine only once the next result is ready.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_top
  import ffra_pkg::*;
#(
  parameter int ENTRY_COUNT = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,   // object_id[14:0], request_size[38:15], zero pad
  input  logic [1:0]           s_tuser,   // command[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [39:0]          m_tdata,   // status[1:0], region_address[33:2], present[34]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [ADDR_W-1:0]    cfg_data
);

  logic [ADDR_W-1:0] bank_base;
  logic [SIZE_W-1:0] bank_size;
  request_t          in_req;
  logic              res_valid;
  logic              res_ready;
  result_t           res;
  result_t           out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_base <= BANK_BASE_RESET;
      bank_size <= BANK_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BANK_BASE: bank_base <= cfg_data;
        REG_BANK_SIZE: bank_size <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_req.cmd  = cmd_t'(s_tuser);
    in_req.id   = s_tdata[ID_W-1:0];
    in_req.size = s_tdata[ID_W+SIZE_W-1:ID_W];
  end

  ffra_engine #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (in_req),
    .bank_base (bank_base),
    .bank_size (bank_size),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register parts the engine from the result stream.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {5'b00000, out_res.present, out_res.addr, out_res.status};

  // A result carries an address only for a successful allocate.
  a_addr_only_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[33:2] == '0))
    else $error("address on a failed result");

  // Present can only be reported alongside an ok status.
  a_present_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[34] |-> (m_tdata[1:0] == ST_OK))
    else $error("present set with a failure status");

  // The engine never offers a result while it is free to take a request.
  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !res_valid)
    else $error("result offered while idle");

  // Once a request is taken the engine is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken back to back");

endmodule

@@ bench/region_table_checker.sv @@
// ----------------------------------------------------------------------------
// region_table_checker
// Watches the request, result and register ports of the allocator, keeps
// its own copy of the region table and compares every result it sees.
// ----------------------------------------------------------------------------
module region_table_checker
  import ffra_pkg::*;
#(
  parameter int ENTRY_COUNT = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [39:0]          s_tdata,   // object_id[14:0], request_size[38:15], zero pad
  input  logic [1:0]           s_tuser,   // command[1:0]
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [39:0]          m_tdata,   // status[1:0], region_address[33:2], present[34]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [ADDR_W-1:0]    cfg_data,
  output int unsigned          fail_count,
  output int unsigned          pending,
  output int unsigned          results_seen,
  output int unsigned          peak_live,
  output int unsigned          full_hits,
  output int unsigned          no_gap_hits,
  output int unsigned          not_found_hits
);

  localparam int REPORT_CAP = 100;

  logic [ADDR_W-1:0] base_q;
  logic [SIZE_W-1:0] span_q;
  logic [ID_W-1:0]   live_id    [ENTRY_COUNT];
  logic [SIZE_W-1:0] live_start [ENTRY_COUNT];
  logic [OFF_W-1:0]  live_end   [ENTRY_COUNT];
  int                live;
  result_t           awaited [$];

  int unsigned fails, seen, peak, n_full, n_no_gap, n_not_found;

  initial begin
    fails = 0;
    seen = 0;
    peak = 0;
    n_full = 0;
    n_no_gap = 0;
    n_not_found = 0;
    live = 0;
  end

  // Lowest-addressed entry with this id, or the live count if there is none.
  function automatic int locate_id(input logic [ID_W-1:0] id);
    int k;
    for (k = 0; k < live; k++) begin
      if (live_id[k] == id) return k;
    end
    return live;
  endfunction

  function automatic result_t apply_request(input cmd_t op, input logic [ID_W-1:0] id,
                                            input logic [SIZE_W-1:0] len);
    result_t          r;
    int               slot;
    int               k;
    logic [OFF_W-1:0] prev;
    logic [31:0]      reach;
    logic [OFF_W-1:0] head;
    r = '0;
    case (op)
      CMD_ALLOC: begin
        if (live >= ENTRY_COUNT) begin
          r.status = ST_FULL;
        end else begin
          // Walk the gaps from the bank base; an entry that starts below the
          // previous end leaves a gap of zero, which only a zero size fits.
          prev = '0;
          slot = 0;
          while (slot < live) begin
            head = {1'b0, live_start[slot]};
            if (head >= prev ? (head - prev >= {1'b0, len}) : (len == '0)) break;
            prev = live_end[slot];
            slot++;
          end
          reach = {7'b0, prev} + {8'b0, len};
          if (reach > {8'b0, span_q}) begin
            r.status = ST_NO_GAP;
          end else begin
            for (k = live; k > slot; k--) begin
              live_id[k]    = live_id[k-1];
              live_start[k] = live_start[k-1];
              live_end[k]   = live_end[k-1];
            end
            live_id[slot]    = id;
            live_start[slot] = prev[SIZE_W-1:0];
            live_end[slot]   = reach[OFF_W-1:0];
            live++;
            r.addr = base_q + {7'b0, prev};
          end
        end
      end
      CMD_FREE: begin
        slot = locate_id(id);
        if (slot >= live) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (k = slot; k + 1 < live; k++) begin
            live_id[k]    = live_id[k+1];
            live_start[k] = live_start[k+1];
            live_end[k]   = live_end[k+1];
          end
          live--;
        end
      end
      CMD_QUERY: begin
        r.present = (locate_id(id) < live);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic void note_failure();
    fails++;
    if (fails == REPORT_CAP) $display("further mismatches are counted but not shown");
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      base_q = BANK_BASE_RESET;
      span_q = BANK_SIZE_RESET;
      live = 0;
      awaited.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen++;
        got.status  = status_t'(m_tdata[1:0]);
        got.addr    = m_tdata[33:2];
        got.present = m_tdata[34];
        if (awaited.size() == 0) begin
          if (fails < REPORT_CAP) $error("result with no request outstanding: tdata %h", m_tdata);
          note_failure();
        end else begin
          want = awaited.pop_front();
          if (got.status !== want.status) begin
            if (fails < REPORT_CAP)
              $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
            note_failure();
          end
          if (got.addr !== want.addr) begin
            if (fails < REPORT_CAP)
              $error("region_address: expected %h, got %h", want.addr, got.addr);
            note_failure();
          end
          if (got.present !== want.present) begin
            if (fails < REPORT_CAP)
              $error("present: expected %0d, got %0d", want.present, got.present);
            note_failure();
          end
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_BANK_BASE: base_q = cfg_data;
          REG_BANK_SIZE: span_q = cfg_data[SIZE_W-1:0];
          default: begin
          end
        endcase
      end
      if (s_tvalid && s_tready) begin
        want = apply_request(cmd_t'(s_tuser), s_tdata[ID_W-1:0], s_tdata[ID_W +: SIZE_W]);
        case (want.status)
          ST_FULL:      n_full++;
          ST_NO_GAP:    n_no_gap++;
          ST_NOT_FOUND: n_not_found++;
          default: begin
          end
        endcase
        if (live > peak) peak = live;
        awaited.push_back(want);
      end
    end
    fail_count     <= fails;
    pending        <= awaited.size();
    results_seen   <= seen;
    peak_live      <= peak;
    full_hits      <= n_full;
    no_gap_hits    <= n_no_gap;
    not_found_hits <= n_not_found;
  end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives allocate, free, query and no-op requests into the region allocator over
// several bank settings, with random sender gaps and receiver stalls, and
// leaves the checking to the region table checker.
// ----------------------------------------------------------------------------
module tb;
  import ffra_pkg::*;

  localparam int ENTRY_COUNT    = 32;
  localparam int PHASES         = 6;
  localparam int PHASE_REQUESTS = 130;
  localparam int POOL           = 24;
  localparam int STALL_LIMIT    = 4000;
  localparam int SETTLE         = 2 * ENTRY_COUNT + 10;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [39:0]          s_tdata = '0;
  logic [1:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [39:0]          m_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [ADDR_W-1:0]    cfg_data = '0;

  int unsigned fail_count, pending, results_seen, peak_live;
  int unsigned full_hits, no_gap_hits, not_found_hits;

  logic [ID_W-1:0]   id_pool    [POOL];
  logic [ADDR_W-1:0] phase_base [PHASES];
  logic [SIZE_W-1:0] phase_span [PHASES];

  int unsigned requests_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  logic        timed_out = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  first_fit_region_allocator_top #(.ENTRY_COUNT(ENTRY_COUNT)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  region_table_checker #(.ENTRY_COUNT(ENTRY_COUNT)) u_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen),
    .peak_live(peak_live), .full_hits(full_hits), .no_gap_hits(no_gap_hits),
    .not_found_hits(not_found_hits)
  );

  // Receiver: each stretch picks a mode, from always ready to mostly stalled.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 150);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 1) == 1);
      2:       m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic send_request(input cmd_t op, input logic [ID_W-1:0] id,
                              input logic [SIZE_W-1:0] len);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, len, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 16);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Stop sending and wait until every request has its result back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_bank(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] span);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_BANK_BASE;
    cfg_data <= base;
    @(posedge clk);
    cfg_addr <= REG_BANK_SIZE;
    cfg_data <= {8'h00, span};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 19) == 0) return ID_W'($urandom);
    return id_pool[$urandom_range(0, POOL - 1)];
  endfunction

  // Mostly sizes that let the table fill up, with some that cannot fit.
  function automatic logic [SIZE_W-1:0] pick_size(input logic [SIZE_W-1:0] span);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 80) return SIZE_W'($urandom_range(1, (span >> 5) + 1));
    if (r < 92) return SIZE_W'($urandom_range(0, span));
    return SIZE_W'($urandom);
  endfunction

  function automatic cmd_t pick_cmd(input int unsigned mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (r < 70) return CMD_ALLOC;
        if (r < 80) return CMD_FREE;
        if (r < 95) return CMD_QUERY;
      end
      1: begin
        if (r < 15) return CMD_ALLOC;
        if (r < 65) return CMD_FREE;
        if (r < 95) return CMD_QUERY;
      end
      default: begin
        if (r < 40) return CMD_ALLOC;
        if (r < 70) return CMD_FREE;
        if (r < 95) return CMD_QUERY;
      end
    endcase
    return CMD_NOP;
  endfunction

  task automatic run_directed();
    send_request(CMD_QUERY, 15'h0000, 24'h000000);
    send_request(CMD_FREE,  15'h0005, 24'h000000);
    send_request(CMD_ALLOC, 15'h0000, 24'h000000);
    send_request(CMD_ALLOC, 15'h7fff, 24'hffffff);
    send_request(CMD_ALLOC, 15'h0001, 24'h100000);  // exactly fills the bank
    send_request(CMD_ALLOC, 15'h0002, 24'h000001);
    send_request(CMD_ALLOC, 15'h0002, 24'h000000);
    send_request(CMD_QUERY, 15'h7fff, 24'h000000);
    send_request(CMD_QUERY, 15'h0001, 24'hffffff);
    send_request(CMD_FREE,  15'h0001, 24'h000000);
    send_request(CMD_ALLOC, 15'h0003, 24'h000010);
    send_request(CMD_ALLOC, 15'h0003, 24'h000010);
    send_request(CMD_QUERY, 15'h0003, 24'h000000);
    send_request(CMD_FREE,  15'h0003, 24'h000000);
    send_request(CMD_QUERY, 15'h0003, 24'h000000);
    send_request(CMD_FREE,  15'h0000, 24'h000000);
    send_request(CMD_FREE,  15'h0000, 24'h000000);
    send_request(CMD_NOP,   15'h7fff, 24'hffffff);
    send_request(CMD_NOP,   15'h0000, 24'h000000);
    send_request(CMD_ALLOC, 15'h2aaa, 24'h555555);
    send_request(CMD_QUERY, 15'h5555, 24'haaaaaa);
  endtask

  task automatic run_random();
    int          p;
    int          n;
    int unsigned mode;
    cmd_t        op;
    for (p = 0; p < PHASES; p++) begin
      drain_results();
      set_bank(phase_base[p], phase_span[p]);
      for (n = 0; n < PHASE_REQUESTS; n++) begin
        if (p == 2 && n == PHASE_REQUESTS / 2) drain_results();
        mode = (n / 40 + p) % 3;
        op = pick_cmd(mode);
        send_request(op, pick_id(),
                     (op == CMD_ALLOC) ? pick_size(phase_span[p]) : SIZE_W'($urandom));
      end
    end
  endtask

  initial begin
    int k;
    for (k = 0; k < POOL; k++) id_pool[k] = ID_W'($urandom);
    id_pool[0] = 15'h0000;
    id_pool[1] = 15'h7fff;
    phase_base[0] = 32'h0000_0000;  phase_span[0] = 24'h10_0000;
    phase_base[1] = 32'hffff_ff00;  phase_span[1] = 24'hff_ffff;
    phase_base[2] = $urandom;       phase_span[2] = 24'h00_1000;
    phase_base[3] = 32'hffff_ffff;  phase_span[3] = 24'h00_0000;
    phase_base[4] = $urandom;
    phase_span[4] = SIZE_W'($urandom_range(24'h01_0000, 24'h10_0000));
    phase_base[5] = 32'h8000_0000;  phase_span[5] = 24'hff_ffff;

    fork
      begin
        repeat (9) @(posedge clk);
        rst <= 1'b0;
        run_directed();
        run_random();
        drain_results();
        repeat (SETTLE) @(posedge clk);
      end
      begin
        wait (idle_cycles >= STALL_LIMIT);
        timed_out = 1'b1;
      end
    join_any
    disable fork;

    $display("Sent %0d requests over %0d bank settings, %0d results compared, table peaked at %0d of %0d.",
             requests_sent, PHASES + 1, results_seen, peak_live, ENTRY_COUNT);
    $display("Seen: table full %0d, no gap %0d, id not found %0d.",
             full_hits, no_gap_hits, not_found_hits);
    if (timed_out || fail_count != 0) begin
      $display("TEST FAILED");
    end else begin
      $display("TEST PASSED");
    end
    $finish;
  end

endmodule
